>>> src/tccs_pkg.sv
// Shared types and constants for the text console cursor/scroll engine.
// Used by tccs_ctrl, tccs_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  // Field widths of the input and result beats.
  localparam int OPCODE_W   = 3;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int COORD_W    = 8;
  localparam int CELL_W     = 16;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_ROW_W  = 5;

  // Character codes and the blank cell.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

  // Operation codes; the remaining codes are no-ops.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT_CHAR     = 3'd0,
    OP_SET_CURSOR   = 3'd1,
    OP_CLEAR_SCREEN = 3'd2,
    OP_CLEAR_LINE   = 3'd3,
    OP_READ_CELL    = 3'd4
  } op_t;

  // Region and value of a fill sweep.
  typedef enum logic [1:0] {
    FILL_ALL    = 2'd0,
    FILL_LINE   = 2'd1,
    FILL_BOTTOM = 2'd2
  } fill_kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_BOOT      = 3'd0,
    ST_BOOT_FILL = 3'd1,
    ST_IDLE      = 3'd2,
    ST_EXEC      = 3'd3,
    ST_COPY      = 3'd4,
    ST_FILL      = 3'd5,
    ST_DONE      = 3'd6
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       item_load;
    logic       exec;
    logic       copy_start;
    logic       copy_step;
    logic       fill_start;
    fill_kind_t fill_kind;
    logic       fill_step;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic line_ok;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> src/tccs_ctrl.sv
// Controller state machine of the console engine.
// Sequences item execution, scroll copy and fill sweeps; uses tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  tccs_pkg::status_t      sts,
  output tccs_pkg::cmd_t         cmd
);
  import tccs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BOOT: begin
        state_nxt = ST_BOOT_FILL;
      end
      ST_BOOT_FILL: begin
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.op)
          OP_PUT_CHAR:     state_nxt = sts.need_scroll ? ST_COPY : ST_DONE;
          OP_CLEAR_SCREEN: state_nxt = ST_FILL;
          OP_CLEAR_LINE:   state_nxt = sts.line_ok ? ST_FILL : ST_DONE;
          default:         state_nxt = ST_DONE;
        endcase
      end
      ST_COPY: begin
        if (sts.copy_last) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sts.fill_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_BOOT;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_BOOT: begin
        cmd.fill_start = 1'b1;
        cmd.fill_kind  = FILL_ALL;
      end
      ST_BOOT_FILL: begin
        cmd.fill_step = 1'b1;
      end
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.item_load = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_PUT_CHAR: begin
            cmd.copy_start = sts.need_scroll;
          end
          OP_CLEAR_SCREEN: begin
            cmd.fill_start = 1'b1;
            cmd.fill_kind  = FILL_ALL;
          end
          OP_CLEAR_LINE: begin
            cmd.fill_start = sts.line_ok;
            cmd.fill_kind  = FILL_LINE;
          end
          default: begin
            cmd.fill_start = 1'b0;
          end
        endcase
      end
      ST_COPY: begin
        cmd.copy_step  = 1'b1;
        cmd.fill_start = sts.copy_last;
        cmd.fill_kind  = FILL_BOTTOM;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/tccs_datapath.sv
// Datapath of the console engine: cursor, cell memory, sweep counter and
// result register. Driven by tccs_ctrl commands; uses tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_datapath #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [tccs_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [tccs_pkg::CHAR_W-1:0]       in_char_code,
  input  wire logic [tccs_pkg::COLOR_W-1:0]      in_fg_color,
  input  wire logic [tccs_pkg::COLOR_W-1:0]      in_bg_color,
  input  wire logic [tccs_pkg::COORD_W-1:0]      in_col,
  input  wire logic [tccs_pkg::COORD_W-1:0]      in_row,
  input  tccs_pkg::cmd_t                         cmd,
  output tccs_pkg::status_t                      sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tccs_pkg::CELL_W-1:0]            out_cell_data,
  output logic [tccs_pkg::CUR_COL_W-1:0]         out_cursor_col,
  output logic [tccs_pkg::CUR_ROW_W-1:0]         out_cursor_row,
  output logic                                   out_scrolled
);
  import tccs_pkg::*;

  localparam int CW     = $clog2(NUM_COLS);
  localparam int RW     = $clog2(NUM_ROWS);
  localparam int CELLS  = NUM_COLS * NUM_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int COPY_N = CELLS - NUM_COLS;
  localparam int TAB_M  = (NUM_COLS + TAB_STOP - 1) / TAB_STOP;

  // Latched item.
  logic [OPCODE_W-1:0] item_op_r;
  logic [CHAR_W-1:0]   item_ch_r;
  logic [COLOR_W-1:0]  item_fg_r;
  logic [COLOR_W-1:0]  item_bg_r;
  logic [COORD_W-1:0]  item_col_r;
  logic [COORD_W-1:0]  item_row_r;

  // Cursor and per-item flags.
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;
  logic          scroll_r;
  logic          rd_hit_r;

  // Sweep counter and fill settings.
  logic [AW-1:0]     cnt_r;
  logic [AW-1:0]     end_r;
  logic [CELL_W-1:0] fill_val_r;

  // Cell memory.
  logic [CELL_W-1:0] cell_mem_r [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  // Result register.
  logic                 out_valid_r;
  logic [CELL_W-1:0]    out_cell_r;
  logic [CUR_COL_W-1:0] out_col_r;
  logic [CUR_ROW_W-1:0] out_row_r;
  logic                 out_scroll_r;

  op_t           op;
  logic          item_in;
  logic          row_ok;
  logic [AW-1:0] line_base;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] tab_col;
  logic          tab_wrap;
  logic [CW-1:0] col_nx;
  logic [RW-1:0] row_nx;
  logic          row_adv;
  logic          wr_cell;
  logic          at_bottom;
  logic          need_scroll;
  logic          copy_last;
  logic          fill_last;
  logic          we;
  logic [AW-1:0] wa;
  logic [CELL_W-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;

  // Capture the item on its accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op_r  <= in_opcode;
      item_ch_r  <= in_char_code;
      item_fg_r  <= in_fg_color;
      item_bg_r  <= in_bg_color;
      item_col_r <= in_col;
      item_row_r <= in_row;
    end
  end

  // Decode of the latched item and cell addresses.
  always_comb begin
    op        = op_t'(item_op_r);
    row_ok    = 9'(item_row_r) < 9'(NUM_ROWS);
    item_in   = row_ok && (9'(item_col_r) < 9'(NUM_COLS));
    line_base = AW'(item_row_r[RW-1:0]) * AW'(NUM_COLS);
    item_addr = line_base + AW'(item_col_r[CW-1:0]);
    cur_addr  = AW'(cur_row_r) * AW'(NUM_COLS) + AW'(cur_col_r);
  end

  // Next tab stop: the smallest multiple of TAB_STOP above the cursor column.
  always_comb begin
    tab_col  = '0;
    tab_wrap = 1'b1;
    for (int m = TAB_M; m >= 1; m--) begin
      if ((m * TAB_STOP) > int'(cur_col_r)) begin
        tab_wrap = (m * TAB_STOP) >= NUM_COLS;
        tab_col  = tab_wrap ? '0 : CW'(m * TAB_STOP);
      end
    end
  end

  // Cursor movement for a put character.
  always_comb begin
    row_adv = 1'b0;
    wr_cell = 1'b0;
    col_nx  = cur_col_r;
    if (item_ch_r == CH_NEWLINE) begin
      col_nx  = '0;
      row_adv = 1'b1;
    end else if (item_ch_r == CH_TAB) begin
      col_nx  = tab_col;
      row_adv = tab_wrap;
    end else begin
      wr_cell = 1'b1;
      if (cur_col_r == CW'(NUM_COLS - 1)) begin
        col_nx  = '0;
        row_adv = 1'b1;
      end else begin
        col_nx = cur_col_r + 1'b1;
      end
    end
    at_bottom   = cur_row_r == RW'(NUM_ROWS - 1);
    need_scroll = row_adv && at_bottom;
    row_nx      = (row_adv && !at_bottom) ? cur_row_r + 1'b1 : cur_row_r;
  end

  // Cursor and per-item flags update when the item executes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      scroll_r  <= 1'b0;
      rd_hit_r  <= 1'b0;
    end else if (cmd.exec) begin
      scroll_r <= (op == OP_PUT_CHAR) && need_scroll;
      rd_hit_r <= (op == OP_READ_CELL) && item_in;
      case (op)
        OP_PUT_CHAR: begin
          cur_col_r <= col_nx;
          cur_row_r <= row_nx;
        end
        OP_SET_CURSOR: begin
          if (item_in) begin
            cur_col_r <= item_col_r[CW-1:0];
            cur_row_r <= item_row_r[RW-1:0];
          end
        end
        OP_CLEAR_SCREEN: begin
          cur_col_r <= '0;
          cur_row_r <= '0;
        end
        default: begin
          cur_col_r <= cur_col_r;
        end
      endcase
    end
  end

  // Sweep counter: scroll copy runs one step past the last read to drain
  // the final write, fills write one cell a cycle up to end_r.
  always_comb begin
    copy_last = cnt_r == AW'(COPY_N);
    fill_last = cnt_r == end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      end_r <= '0;
    end else if (cmd.fill_start) begin
      case (cmd.fill_kind)
        FILL_LINE: begin
          cnt_r <= line_base;
          end_r <= line_base + AW'(NUM_COLS - 1);
        end
        FILL_BOTTOM: begin
          cnt_r <= AW'(COPY_N);
          end_r <= AW'(CELLS - 1);
        end
        default: begin
          cnt_r <= '0;
          end_r <= AW'(CELLS - 1);
        end
      endcase
    end else if (cmd.copy_start) begin
      cnt_r <= '0;
    end else if (cmd.copy_step || cmd.fill_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // The bottom row after a scroll is filled with background-colored spaces.
  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      if (cmd.fill_kind == FILL_BOTTOM) begin
        fill_val_r <= {item_bg_r, item_bg_r, CH_SPACE};
      end else begin
        fill_val_r <= BLANK_CELL;
      end
    end
  end

  // Memory port selection.
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = fill_val_r;
    re = 1'b0;
    ra = item_addr;
    if (cmd.exec && (op == OP_PUT_CHAR) && wr_cell) begin
      we = 1'b1;
      wa = cur_addr;
      wd = {item_bg_r, item_fg_r, item_ch_r};
    end else if (cmd.copy_step && (cnt_r != '0)) begin
      we = 1'b1;
      wa = cnt_r - 1'b1;
      wd = rd_data_r;
    end else if (cmd.fill_step) begin
      we = 1'b1;
    end
    if (cmd.exec && (op == OP_READ_CELL) && item_in) begin
      re = 1'b1;
    end else if (cmd.copy_step && !copy_last) begin
      re = 1'b1;
      ra = cnt_r + AW'(NUM_COLS);
    end
  end

  // Cell memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem_r[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= cell_mem_r[ra];
    end
  end

  // Result register: holds a finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r   <= rd_hit_r ? rd_data_r : '0;
      out_col_r    <= CUR_COL_W'(cur_col_r);
      out_row_r    <= CUR_ROW_W'(cur_row_r);
      out_scroll_r <= scroll_r;
    end
  end

  // Status to the controller and result outputs.
  always_comb begin
    sts.op          = op;
    sts.need_scroll = need_scroll;
    sts.line_ok     = row_ok;
    sts.copy_last   = copy_last;
    sts.fill_last   = fill_last;
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scroll_r;

endmodule

`default_nettype wire

>>> src/text_console_cursor_scroll_core.sv
// Text console engine: NUM_COLS x NUM_ROWS cell store with cursor and scroll.
// Set cursor, read cell, no-ops and a put char without scroll pass through the
// execute and done states; a new item is accepted only once the last result is loaded.
// Scroll adds a row copy (the memory's read and write ports used in step) plus
// a bottom-row fill; clear screen adds a full-screen fill, clear line a one-row fill.
// Reset: a clearing pass over all NUM_COLS*NUM_ROWS cells with in_tready low.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll_core #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: char_code[7:0], fg_color[11:8], bg_color[15:12], col[23:16], row[31:24]
  input  wire logic [31:0] in_tdata,
  // tuser: opcode[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: cell_data[15:0], cursor_col[22:16], cursor_row[27:23], scrolled[28],
  // zero fill[31:29]
  output logic [31:0]      out_tdata
);
  import tccs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  logic [CELL_W-1:0]    cell_data;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic                 scrolled;

  // Controller.
  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath with the input beat unpacked into fields.
  tccs_datapath #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_tuser),
    .in_char_code   (in_tdata[7:0]),
    .in_fg_color    (in_tdata[11:8]),
    .in_bg_color    (in_tdata[15:12]),
    .in_col         (in_tdata[23:16]),
    .in_row         (in_tdata[31:24]),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_cell_data  (cell_data),
    .out_cursor_col (cursor_col),
    .out_cursor_row (cursor_row),
    .out_scrolled   (scrolled)
  );

  // Pack the result beat.
  assign out_tdata = {3'b000, scrolled, cursor_row, cursor_col, cell_data};

`ifndef SYNTH
  // The reported cursor column stays on screen.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[22:16]} < 8'(NUM_COLS)))
    else $error("cursor column beyond right edge");

  // A scroll always leaves the cursor on the bottom row.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> (out_tdata[27:23] == 5'(NUM_ROWS - 1)))
    else $error("scroll reported with cursor off the bottom row");

  // Right after reset, as the clearing pass starts, no beat is taken.
  a_boot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input ready right after reset");
`endif

endmodule

`default_nettype wire
